// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define MSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion, also checked during reset.
`define MSP_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed during or after reset");

`endif

// ----- rtl/msp_chk_pkg.sv -----
// Types and constants of the reply frame checker.
package msp_chk_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 9;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] REPLY_DIRECTION = 8'h3E;
   localparam logic [POS_W-1:0]  HDR_BYTES = 9'd5;

   localparam logic [POS_W-1:0] POS_DIRECTION = 9'd2;
   localparam logic [POS_W-1:0] POS_SIZE      = 9'd3;
   localparam logic [POS_W-1:0] POS_COMMAND   = 9'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXPECTED_COMMAND = 1'b0,
      CSR_EXPECTED_SIZE    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_HEADER_ERROR = 2'd1,
      ST_SIZE_ERROR   = 2'd2,
      ST_CHECKSUM_ERR = 2'd3
   } status_type;

endpackage

// ----- rtl/msp_response_checker_core.sv -----
// Reply frame checker: checks one framed reply a byte at a time.
//
// Input channel req_*: one received byte per item. A frame is two preamble
// bytes, a direction byte ('>'), a size byte, a command byte, expected_size
// payload bytes and an XOR checksum byte.
// Result channel rsp_*: each payload byte is passed out with tlast low and
// tuser ok; the checksum byte yields one verdict item with tlast high, the
// received checksum in tdata and the status in tuser (header error, then
// size mismatch, then bad checksum). Header bytes produce no item.
// Config port csr_*: expected_command (index 0) and expected_size (index 1),
// written while no frame is in flight.
// Output: a result is registered and shows in the cycle after its byte is accepted.
// Throughput: one byte per cycle while req_tready is high; the frame state and
// the single output register update in the cycle a byte is taken.
// Stall: req_tready follows rsp_tready while a result is held, so the block
// keeps taking bytes as long as the held result drains in the same cycle.
// Reset: config and frame registers clear (header-ok flag set), no result is held.
module msp_response_checker_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] rx_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] out_data
   output logic                        rsp_tlast,
   output msp_chk_pkg::status_type     rsp_tuser,   // [1:0] status
   input  logic                        csr_we,
   input  msp_chk_pkg::csr_index_type  csr_index,
   input  logic [7:0]                  csr_wdata
);
   import msp_chk_pkg::*;

   logic [BYTE_W-1:0] exp_cmd_ff, exp_cmd_in;
   logic [BYTE_W-1:0] exp_size_ff, exp_size_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic              hdr_ok_ff, hdr_ok_in;
   logic [BYTE_W-1:0] rsize_ff, rsize_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;
   status_type        out_status_ff, out_status_in;

   logic              accept;
   logic [POS_W-1:0]  crc_pos;
   logic              at_crc;
   logic              emit;
   status_type        verdict;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign crc_pos    = HDR_BYTES + {1'b0, exp_size_ff};
   assign at_crc     = pos_ff >= crc_pos;

   always_comb begin
      if (!hdr_ok_ff) begin
         verdict = ST_HEADER_ERROR;
      end else if (rsize_ff != exp_size_ff) begin
         verdict = ST_SIZE_ERROR;
      end else if (xor_ff != req_tdata) begin
         verdict = ST_CHECKSUM_ERR;
      end else begin
         verdict = ST_OK;
      end
   end

   always_comb begin
      exp_cmd_in  = exp_cmd_ff;
      exp_size_in = exp_size_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED_COMMAND: exp_cmd_in  = csr_wdata;
            CSR_EXPECTED_SIZE:    exp_size_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      xor_in    = xor_ff;
      hdr_ok_in = hdr_ok_ff;
      rsize_in  = rsize_ff;
      emit      = 1'b0;
      out_last_in   = 1'b0;
      out_status_in = ST_OK;
      out_data_in   = req_tdata;
      if (accept) begin
         if (at_crc) begin
            emit          = 1'b1;
            out_last_in   = 1'b1;
            out_status_in = verdict;
            pos_in    = '0;
            xor_in    = '0;
            hdr_ok_in = 1'b1;
            rsize_in  = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            case (pos_ff)
               POS_DIRECTION: begin
                  if (req_tdata != REPLY_DIRECTION) hdr_ok_in = 1'b0;
               end
               POS_SIZE: begin
                  rsize_in = req_tdata;
                  xor_in   = xor_ff ^ req_tdata;
               end
               POS_COMMAND: begin
                  if (req_tdata != exp_cmd_ff) hdr_ok_in = 1'b0;
                  xor_in = xor_ff ^ req_tdata;
               end
               default: begin
                  // preamble bytes are skipped, anything later is payload
                  if (pos_ff > POS_COMMAND) begin
                     xor_in = xor_ff ^ req_tdata;
                     emit   = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      if (accept) begin
         out_valid_in = emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cmd_ff   <= '0;
         exp_size_ff  <= '0;
         pos_ff       <= '0;
         xor_ff       <= '0;
         hdr_ok_ff    <= 1'b1;
         rsize_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         exp_cmd_ff   <= exp_cmd_in;
         exp_size_ff  <= exp_size_in;
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
         hdr_ok_ff    <= hdr_ok_in;
         rsize_ff     <= rsize_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_data_ff   <= out_data_in;
         out_last_ff   <= out_last_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ----- rtl/msp_chk_checker.sv -----
// Port-level checks of the reply frame checker, bound to the top level.
`include "assert_macros.svh"

module msp_chk_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic                    rsp_tlast,
   input msp_chk_pkg::status_type rsp_tuser
);
   import msp_chk_pkg::*;

   `MSP_ASSERT_RST(a_idle_after_reset, clock, reset |=> !rsp_tvalid)

   `MSP_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)

   `MSP_ASSERT(a_payload_status_ok, clock, reset,
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == ST_OK))

   `MSP_ASSERT(a_stall_holds_valid, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)

endmodule

bind msp_response_checker_core msp_chk_checker u_msp_chk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
